FILE: rtl/core/xpg_pkg.sv
// Package for the XOR parity group FEC encoder.
// Holds shared widths, result kind codes, the controller state type and the
// command and status structs; no dependencies.
`default_nettype none
package xpg_pkg;
  localparam int MaxPayload = 2048;
  localparam int LenW = 12;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_PARITY = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_WRITE,
    ST_OUT
  } state_t;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_GSIZE  = 2'd1;
  localparam logic [1:0] REG_MINGS  = 2'd2;

  typedef struct packed {
    logic start;      // latch input item, classify it
    logic div_step;   // one restoring division step
    logic mem_read;   // issue store read for the current item
    logic mem_write;  // finish the item: write store, update state, form result
  } cmd_t;

  typedef struct packed {
    logic need_div;   // item opens a frame and needs the group count
    logic need_mem;   // item touches the parity store
    logic div_done;
  } status_t;
endpackage
`default_nettype wire

FILE: rtl/core/xpg_if.sv
// Valid/ready channel interfaces for the XOR parity group FEC encoder.
// Depends on nothing but the widths of the work items.
`default_nettype none
interface xpg_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  data_byte;
  logic        byte_present;
  logic        packet_end;
  logic [9:0]  frame_packets;
  logic [31:0] base_seq;
  logic [15:0] stream_id;
  logic [31:0] timestamp_ms;
  modport source (output valid, func, data_byte, byte_present, packet_end,
                  frame_packets, base_seq, stream_id, timestamp_ms, input ready);
  modport sink (input valid, func, data_byte, byte_present, packet_end,
                frame_packets, base_seq, stream_id, timestamp_ms, output ready);
endinterface

interface xpg_out_if #(parameter int LenW = 12);
  logic            valid;
  logic            ready;
  logic [1:0]      kind;
  logic [31:0]     fec_seq;
  logic [15:0]     out_stream_id;
  logic [31:0]     out_timestamp_ms;
  logic [31:0]     group_base_seq;
  logic [7:0]      packets_in_group;
  logic [15:0]     length_xor;
  logic [7:0]      group_index;
  logic [7:0]      group_count;
  logic [LenW-1:0] parity_length;
  logic [7:0]      parity_byte;
  logic            parity_last;
  modport source (output valid, kind, fec_seq, out_stream_id, out_timestamp_ms,
                  group_base_seq, packets_in_group, length_xor, group_index,
                  group_count, parity_length, parity_byte, parity_last, input ready);
  modport sink (input valid, kind, fec_seq, out_stream_id, out_timestamp_ms,
                group_base_seq, packets_in_group, length_xor, group_index,
                group_count, parity_length, parity_byte, parity_last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/xpg_ctrl.sv
// Controller of the XOR parity group FEC encoder.
// Sequences each item through division, store read and update; uses xpg_pkg.
`default_nettype none
module xpg_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire xpg_pkg::status_t status,
  output xpg_pkg::cmd_t         cmd
);
  xpg_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xpg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      xpg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = xpg_pkg::ST_DIV;
        end
      end
      xpg_pkg::ST_DIV: begin
        if (status.need_div && !status.div_done) begin
          cmd.div_step = 1'b1;
        end else begin
          if (status.need_mem) begin
            cmd.mem_read = 1'b1;
          end
          state_next = xpg_pkg::ST_WRITE;
        end
      end
      xpg_pkg::ST_WRITE: begin
        cmd.mem_write = 1'b1;
        state_next = xpg_pkg::ST_OUT;
      end
      xpg_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = xpg_pkg::ST_IDLE;
        end
      end
      default: state_next = xpg_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/core/xpg_dp.sv
// Datapath of the XOR parity group FEC encoder: parity store, group and frame
// counters, group-count divider and the result register. Uses xpg_pkg.
`default_nettype none
module xpg_dp #(
  parameter int MAX_PAYLOAD = xpg_pkg::MaxPayload,
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  localparam int LW = $clog2(MAX_PAYLOAD + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [7:0]    cfg_data,
  input  wire xpg_pkg::cmd_t cmd,
  output xpg_pkg::status_t   status,
  xpg_in_if.sink             din,
  xpg_out_if.source          dout
);
  logic       fec_enable;
  logic [7:0] group_size;
  logic [7:0] min_group_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      fec_enable <= 1'b1;
      group_size <= 8'd4;
      min_group_size <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        xpg_pkg::REG_ENABLE: fec_enable <= cfg_data[0];
        xpg_pkg::REG_GSIZE:  group_size <= cfg_data;
        xpg_pkg::REG_MINGS:  min_group_size <= cfg_data;
        default: ;
      endcase
    end
  end

  wire [7:0] eff_gs = (group_size == 8'd0) ? 8'd1 : group_size;

  // Latched item.
  logic        i_func, i_present, i_pend;
  logic [7:0]  i_data;
  logic [9:0]  i_fp;
  logic [31:0] i_base, i_ts;
  logic [15:0] i_sid;
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      i_func <= din.func;
      i_data <= din.data_byte;
      i_present <= din.byte_present;
      i_pend <= din.packet_end;
      i_fp <= din.frame_packets;
      i_base <= din.base_seq;
      i_sid <= din.stream_id;
      i_ts <= din.timestamp_ms;
    end
  end

  // State.
  logic [LW-1:0] gmax, bpos, dptr;
  logic [15:0]   lxor;
  logic [7:0]    pcnt, gnum, gcount;
  logic [9:0]    pleft;
  logic [31:0]   fbase, fts, nseq;
  logic [15:0]   fsid;
  logic          dpend;

  // Item classification.
  wire push = !i_func;
  wire push_live = push && !dpend && fec_enable && (i_present || i_pend);
  wire opening = push_live && (pleft == 10'd0);
  wire open_bad = opening && (i_fp == 10'd0);
  wire go = push_live && !open_bad;
  wire pull_ok = i_func && dpend && (dptr < LW'(MAX_PAYLOAD));
  wire wr_byte_pre = i_present && ((opening ? LW'(0) : bpos) < LW'(MAX_PAYLOAD));

  // Restoring divider for (fp + gs - 1) / gs, one quotient bit a cycle.
  logic [10:0] dq;
  logic [8:0]  drem;
  logic [3:0]  dcnt;
  wire  [9:0]  dtrial = {drem, dq[10]} - {2'b0, eff_gs};
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dq <= {1'b0, din.frame_packets} + {3'b0, (group_size == 8'd0) ? 8'd1 : group_size}
            - 11'd1;
      drem <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      if (!dtrial[9]) begin
        drem <= dtrial[8:0];
        dq <= {dq[9:0], 1'b1};
      end else begin
        drem <= {drem[7:0], dq[10]};
        dq <= {dq[9:0], 1'b0};
      end
      dcnt <= dcnt + 4'd1;
    end
  end

  assign status.need_div = opening && !open_bad;
  assign status.div_done = (dcnt == 4'd11);
  assign status.need_mem = (go && wr_byte_pre) || pull_ok;

  // Parity store, one read and one write port.
  logic [7:0]    store [MAX_PAYLOAD];
  logic [7:0]    rdata;
  wire  [LW-1:0] cur_bpos = opening ? LW'(0) : bpos;
  wire  [LW-1:0] cur_gmax = opening ? LW'(0) : gmax;
  wire  [LW-1:0] raddr = i_func ? dptr : cur_bpos;
  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      rdata <= store[raddr[AW-1:0]];
    end
  end
  wire [7:0] old_b = (cur_bpos < cur_gmax) ? rdata : 8'd0;
  always_ff @(posedge clk) begin
    if (cmd.mem_write && go && wr_byte_pre) begin
      store[cur_bpos[AW-1:0]] <= old_b ^ i_data;
    end
  end

  // Next values after the byte step and packet end.
  wire [LW-1:0] bpos1 = wr_byte_pre ? cur_bpos + LW'(1) : cur_bpos;
  wire [LW-1:0] gmax1 = (bpos1 > cur_gmax) ? bpos1 : cur_gmax;
  wire [15:0]   lxor0 = opening ? 16'd0 : lxor;
  wire [15:0]   lxor1 = lxor0 ^ 16'(bpos1);
  wire [7:0]    pcnt0 = opening ? 8'd0 : pcnt;
  wire [7:0]    pcnt1 = pcnt0 + 8'd1;
  wire [9:0]    pleft0 = opening ? i_fp : pleft;
  wire [9:0]    pleft1 = pleft0 - 10'd1;
  wire [31:0]   fbase0 = opening ? i_base : fbase;
  wire [31:0]   fts0 = opening ? i_ts : fts;
  wire [15:0]   fsid0 = opening ? i_sid : fsid;
  wire [7:0]    gnum0 = opening ? 8'd0 : gnum;
  wire [7:0]    gcnt0 = opening ? dq[7:0] : gcount;
  wire          closing = i_pend && ((pcnt1 >= eff_gs) || (pleft1 == 10'd0));
  wire          emit = closing && (pcnt1 >= min_group_size);
  wire          starts_drain = emit && (gmax1 != LW'(0));
  wire          last_pull = (dptr + LW'(1)) >= gmax;

  always_ff @(posedge clk) begin
    if (rst) begin
      gmax <= '0; bpos <= '0; dptr <= '0; lxor <= '0; pcnt <= '0;
      gnum <= '0; gcount <= '0; pleft <= '0; fbase <= '0; fts <= '0;
      nseq <= '0; fsid <= '0; dpend <= 1'b0;
    end else if (cmd.mem_write) begin
      if (pull_ok) begin
        if (last_pull) begin
          dpend <= 1'b0; dptr <= '0; gmax <= '0;
        end else begin
          dptr <= dptr + LW'(1);
        end
      end else if (go) begin
        fts <= fts0; fsid <= fsid0; gcount <= gcnt0;
        if (!i_pend) begin
          bpos <= bpos1; gmax <= gmax1; lxor <= lxor0; pcnt <= pcnt0;
          pleft <= pleft0; fbase <= fbase0; gnum <= gnum0;
        end else if (!closing) begin
          bpos <= '0; gmax <= gmax1; lxor <= lxor1; pcnt <= pcnt1;
          pleft <= pleft1; fbase <= fbase0; gnum <= gnum0;
        end else begin
          bpos <= '0; lxor <= '0; pcnt <= '0; pleft <= pleft1;
          fbase <= fbase0 + {24'd0, pcnt1};
          gnum <= gnum0 + 8'd1;
          if (emit) nseq <= nseq + 32'd1;
          if (starts_drain) begin
            dpend <= 1'b1; dptr <= '0; gmax <= gmax1;
          end else begin
            gmax <= '0;
          end
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      dout.kind <= xpg_pkg::KIND_ACCEPT;
      dout.fec_seq <= '0; dout.out_stream_id <= '0; dout.out_timestamp_ms <= '0;
      dout.group_base_seq <= '0; dout.packets_in_group <= '0; dout.length_xor <= '0;
      dout.group_index <= '0; dout.group_count <= '0; dout.parity_length <= '0;
      dout.parity_byte <= '0; dout.parity_last <= 1'b0;
      if (i_func) begin
        if (pull_ok) begin
          dout.kind <= xpg_pkg::KIND_PARITY;
          dout.parity_byte <= rdata;
          dout.parity_last <= last_pull;
        end else begin
          dout.kind <= xpg_pkg::KIND_REJECT;
        end
      end else if (dpend || open_bad) begin
        dout.kind <= xpg_pkg::KIND_REJECT;
      end else if (go && emit) begin
        dout.kind <= xpg_pkg::KIND_HEADER;
        dout.fec_seq <= nseq;
        dout.out_stream_id <= fsid0;
        dout.out_timestamp_ms <= fts0;
        dout.group_base_seq <= fbase0;
        dout.packets_in_group <= pcnt1;
        dout.length_xor <= lxor1;
        dout.group_index <= gnum0;
        dout.group_count <= gcnt0;
        dout.parity_length <= xpg_pkg::LenW'(gmax1);
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/xor_parity_group_fec_encoder.sv
// XOR parity group FEC encoder, top level. Each item moves from input transfer
// through the controller states DIV (division and store read), WRITE and OUT,
// where the result is valid; a frame-opening push takes its group count from
// an 11-step serial divider in DIV. A new item is taken only after the last
// result is taken, paced by the store read-modify-write and result handshake.
// Synchronous active-high reset; the parity store itself is not cleared.
`default_nettype none
module xor_parity_group_fec_encoder #(
  parameter int MAX_PAYLOAD = xpg_pkg::MaxPayload
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  xpg_in_if.sink          din,
  xpg_out_if.source       dout
);
  xpg_pkg::cmd_t    cmd;
  xpg_pkg::status_t status;

  xpg_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(din.valid), .in_ready(din.ready),
    .out_valid(dout.valid), .out_ready(dout.ready), .status(status), .cmd(cmd)
  );

  xpg_dp #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cmd(cmd), .status(status), .din(din), .dout(dout)
  );
endmodule
`default_nettype wire

FILE: rtl/core/xpg_checker.sv
// Port-level checker for the XOR parity group FEC encoder, bound to the top.
// Depends on the top level's port names.
`default_nettype none
module xpg_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] kind,
  input wire logic       parity_last
);
  // One item in flight: no input is taken while a result is shown.
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input ready while result pending");
  // A result transfer returns the block to accepting input.
  a_ret: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready)
    else $error("not ready after result");
  // An input transfer never yields a result in the next cycle.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early");
  // The last-byte mark only comes with parity bytes.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && parity_last |-> kind == xpg_pkg::KIND_PARITY)
    else $error("parity_last on non-parity result");
endmodule

bind xor_parity_group_fec_encoder xpg_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(din.valid), .in_ready(din.ready),
  .out_valid(dout.valid), .out_ready(dout.ready), .kind(dout.kind),
  .parity_last(dout.parity_last)
);
`default_nettype wire
